// File: src/uart_bds_pkg.sv
package uart_bds_pkg;

	localparam int CLK_W  = 30;
	localparam int BAUD_W = 22;
	localparam int DIVR_W = 8;
	localparam int GEN_W  = 32;

	// The shared divider works on words of this width.
	localparam int DIV_W = 32;
	localparam int CNT_W = $clog2(DIV_W + 1);

	localparam logic [DIVR_W-1:0] DIVIDER_LIMIT = 8'd255;
	localparam logic [DIVR_W-1:0] FIRST_DIVIDER = 8'd4;

	localparam logic [CLK_W-1:0]  CLK_RESET     = 30'd125000000;
	localparam logic [CLK_W-1:0]  SLOW_CLOCK_HZ = 30'd1000000;
	localparam logic [BAUD_W-1:0] SLOW_BAUD_CAP = 22'd4800;

	localparam logic [GEN_W-1:0] GEN_MIN = 32'd2;
	localparam logic [GEN_W-1:0] GEN_MAX = 32'd65535;

	localparam int ERR_W = 30;
	localparam int PCT_W = 37;
	localparam logic [PCT_W-1:0] PERCENT           = 37'd100;
	localparam logic [PCT_W-1:0] ERR_PERCENT_LIMIT = 37'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GEN_START,
		ST_GEN_WAIT,
		ST_CHECK,
		ST_ACH_START,
		ST_ACH_WAIT,
		ST_CMP,
		ST_NEXT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] num;
		logic [DIV_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
	} div_rsp_t;

	typedef struct packed {
		logic              load;
		logic [DIVR_W-1:0] divider;
		logic [CLK_W-1:0]  generator;
		logic              found;
	} res_t;

endpackage

// File: src/uart_bds_div.sv
module uart_bds_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  uart_bds_pkg::div_req_t req,
	output uart_bds_pkg::div_rsp_t rsp
);
	import uart_bds_pkg::*;

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;

	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic             qbit;

	// Restoring division, one quotient bit per cycle. The dividend shifts out
	// of quo_q at the top while quotient bits shift in at the bottom.
	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign qbit  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= CNT_W'(DIV_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (cnt_q != '0) begin
			rem_q <= qbit ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], qbit};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

// File: src/uart_bds_ctrl.sv
module uart_bds_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [uart_bds_pkg::BAUD_W-1:0]     baud,
	input  logic [uart_bds_pkg::CLK_W-1:0]      clk_hz,
	input  logic                                out_free,
	output logic                                busy,
	output uart_bds_pkg::res_t                  res
);
	import uart_bds_pkg::*;

	state_t state_q;
	state_t state_d;

	logic [BAUD_W-1:0] baud_q;
	logic [DIVR_W-1:0] div_q;
	logic [GEN_W-1:0]  gen_q;
	logic [24:0]       prod_q;
	logic [ERR_W-1:0]  err_q;
	logic              hit_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [8:0]        div_p1;
	logic [30:0]       den_gen;
	logic [DIV_W-1:0]  num_gen;
	logic              gen_ok;
	logic [PCT_W-1:0]  err_pct;
	logic [PCT_W-1:0]  err_lim;
	logic              err_ok;
	logic              last_div;

	uart_bds_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign div_p1   = {1'b0, div_q} + 9'd1;
	assign den_gen  = 31'(baud_q) * 31'(div_p1);
	// Adding half the denominator rounds the quotient to nearest, halves up.
	assign num_gen  = DIV_W'(clk_hz) + DIV_W'(den_gen >> 1);
	assign gen_ok   = (gen_q >= GEN_MIN) && (gen_q <= GEN_MAX);
	// floor(err*100/baud) < 3 holds exactly when err*100 < 3*baud.
	assign err_pct  = PCT_W'(err_q) * PERCENT;
	assign err_lim  = PCT_W'(baud_q) * ERR_PERCENT_LIMIT;
	assign err_ok   = (err_pct < err_lim);
	assign last_div = (div_p1 >= {1'b0, DIVIDER_LIMIT});

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (baud == '0)
						state_d = ST_FINISH;
					else
						state_d = ST_GEN_START;
				end
			end
			ST_GEN_START: state_d = ST_GEN_WAIT;
			ST_GEN_WAIT: begin
				if (div_rsp.done)
					state_d = ST_CHECK;
			end
			ST_CHECK: state_d = gen_ok ? ST_ACH_START : ST_NEXT;
			ST_ACH_START: state_d = ST_ACH_WAIT;
			ST_ACH_WAIT: begin
				if (div_rsp.done)
					state_d = ST_CMP;
			end
			ST_CMP: state_d = err_ok ? ST_FINISH : ST_NEXT;
			ST_NEXT: state_d = last_div ? ST_FINISH : ST_GEN_START;
			ST_FINISH: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = num_gen;
		div_req.den   = DIV_W'(den_gen);
		res.load      = 1'b0;
		case (state_q)
			ST_GEN_START: div_req.start = 1'b1;
			ST_ACH_START: begin
				div_req.start = 1'b1;
				div_req.num   = DIV_W'(clk_hz);
				div_req.den   = DIV_W'(prod_q);
			end
			ST_FINISH: res.load = out_free;
			default: ;
		endcase
	end

	assign busy          = (state_q != ST_IDLE);
	assign res.divider   = hit_q ? div_q : DIVIDER_LIMIT;
	assign res.generator = gen_q[CLK_W-1:0];
	assign res.found     = hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hit_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && start)
				hit_q <= 1'b0;
			else if (state_q == ST_CMP && err_ok)
				hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (clk_hz < SLOW_CLOCK_HZ && baud > SLOW_BAUD_CAP)
						baud_q <= SLOW_BAUD_CAP;
					else
						baud_q <= baud;
					div_q <= FIRST_DIVIDER;
					gen_q <= '0;
				end
			end
			ST_GEN_WAIT: begin
				if (div_rsp.done)
					gen_q <= div_rsp.quot;
			end
			ST_CHECK: prod_q <= 25'(gen_q[15:0]) * 25'(div_p1);
			ST_ACH_WAIT: begin
				if (div_rsp.done) begin
					if ({10'd0, baud_q} > div_rsp.quot)
						err_q <= ERR_W'({10'd0, baud_q} - div_rsp.quot);
					else
						err_q <= ERR_W'(div_rsp.quot - {10'd0, baud_q});
				end
			end
			ST_NEXT: begin
				if (!last_div)
					div_q <= div_p1[DIVR_W-1:0];
			end
			default: ;
		endcase
	end

endmodule

// File: src/uart_baud_divisor_search_core.sv
// UART baud divisor search.
// A transaction on the request channel (req_valid, req_stall, requested_baud)
// starts a search for a divider and generator pair that brings the master
// clock within three percent of the requested baud rate. The result leaves on
// the result channel (res_valid, res_stall, divider, generator, found).
// The master clock frequency is written through cfg_we / cfg_wdata; the user
// must write it only while the block is idle (the block does not enforce it).
// A divider whose generator is in range costs two divisions, a skipped one
// costs one, all on the one shared restoring divider. A full search runs
// over all 251 dividers; a zero request gets its result with no division.
// req_stall is high while a search runs. A finished result sits in the output
// register, so a new request is taken while the old result still waits; if
// the receiver stalls and that search ends too, the block holds its result
// and takes no further request until the output register frees.
// Reset clears both channels and loads the master clock with 125 MHz.
module uart_baud_divisor_search_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [uart_bds_pkg::CLK_W-1:0]     cfg_wdata,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic [uart_bds_pkg::BAUD_W-1:0]    requested_baud,
	output logic                               res_valid,
	input  logic                               res_stall,
	output logic [uart_bds_pkg::DIVR_W-1:0]    divider,
	output logic [uart_bds_pkg::CLK_W-1:0]     generator,
	output logic                               found
);
	import uart_bds_pkg::*;

	logic [CLK_W-1:0]  master_clock_q;
	logic              res_valid_q;
	logic [DIVR_W-1:0] divider_q;
	logic [CLK_W-1:0]  generator_q;
	logic              found_q;

	logic busy;
	logic out_free;
	logic start;
	res_t res;

	assign out_free = !res_valid_q || !res_stall;
	assign start    = req_valid && !busy;

	uart_bds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.baud     (requested_baud),
		.clk_hz   (master_clock_q),
		.out_free (out_free),
		.busy     (busy),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_clock_q <= CLK_RESET;
			res_valid_q    <= 1'b0;
		end else begin
			if (cfg_we)
				master_clock_q <= cfg_wdata;
			if (res.load)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.load) begin
			divider_q   <= res.divider;
			generator_q <= res.generator;
			found_q     <= res.found;
		end
	end

	assign req_stall = busy;
	assign res_valid = res_valid_q;
	assign divider   = divider_q;
	assign generator = generator_q;
	assign found     = found_q;

endmodule

// File: src/uart_bds_checker.sv
module uart_bds_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               req_valid,
	input logic                               req_stall,
	input logic                               res_valid,
	input logic                               res_stall,
	input logic [uart_bds_pkg::DIVR_W-1:0]    divider,
	input logic [uart_bds_pkg::CLK_W-1:0]     generator,
	input logic                               found
);
	import uart_bds_pkg::*;

	// A request transaction always starts a search, which stalls the request channel.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request channel open right after a transaction");

	a_found_divider: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && found) |-> (divider >= FIRST_DIVIDER && divider < DIVIDER_LIMIT))
		else $error("found result with divider outside the search range");

	a_miss_divider: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !found) |-> (divider == DIVIDER_LIMIT))
		else $error("failed search without the limit divider");

	a_found_generator: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && found) |->
			(generator >= CLK_W'(GEN_MIN) && generator <= CLK_W'(GEN_MAX)))
		else $error("found result with generator out of range");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=>
			(res_valid && $stable(divider) && $stable(generator) && $stable(found)))
		else $error("stalled result changed");

endmodule

bind uart_baud_divisor_search_core uart_bds_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.divider   (divider),
	.generator (generator),
	.found     (found)
);
